// ===== design/smq_pkg.sv =====
// Package for the sorted minimum queue: beat structs, operation and status codes,
// and the control word shared by the cell chain. No dependencies.
package smq_pkg;

    localparam int DATA_W        = 32;
    localparam int MODE_W        = 2;
    localparam int STATUS_W      = 2;
    localparam int OUT_COUNT_W   = 5;
    localparam int DEPTH_DEFAULT = 16;

    // Operation codes carried in the mode field of an input beat.
    localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_POP    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd2;

    // Status codes carried in a result beat.
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic [MODE_W-1:0]        mode;
        logic signed [DATA_W-1:0] value;
    } t_in_beat;

    typedef struct packed {
        logic signed [DATA_W-1:0] min_value;
        logic [OUT_COUNT_W-1:0]   count;
        logic                     is_empty;
        logic [STATUS_W-1:0]      status;
    } t_out_beat;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_POP
    } t_cell_op;

    // Broadcast to every cell in the chain.
    typedef struct packed {
        t_cell_op                 op;
        logic signed [DATA_W-1:0] value;
    } t_cell_ctl;

endpackage

// ===== design/smq_cell.sv =====
// One slot of the sorted chain: holds one value and compares it against the broadcast
// insert value. Depends on smq_pkg.
module smq_cell
    import smq_pkg::*;
(
    input  logic                     i_clk,
    input  t_cell_ctl                i_ctl,
    input  logic                     i_occupied,
    input  logic                     i_prev_lt,
    input  logic signed [DATA_W-1:0] i_prev_val,
    input  logic signed [DATA_W-1:0] i_next_val,
    output logic                     o_lt,
    output logic signed [DATA_W-1:0] o_val,
    output logic signed [DATA_W-1:0] o_next_val
);

    logic signed [DATA_W-1:0] r_val;
    logic signed [DATA_W-1:0] n_val;

    // Stored values are ascending, so the cells that are below the new value form
    // a prefix of the chain.
    assign o_lt = i_occupied && (r_val < i_ctl.value);

    always_comb begin
        n_val = r_val;
        case (i_ctl.op)
            CELL_INSERT: begin
                // Keep if smaller; the first cell past the prefix takes the new
                // value; every cell after it takes its left neighbor's value.
                if (o_lt) begin
                    n_val = r_val;
                end else if (i_prev_lt) begin
                    n_val = i_ctl.value;
                end else begin
                    n_val = i_prev_val;
                end
            end
            CELL_POP: begin
                n_val = i_next_val;
            end
            default: begin
                n_val = r_val;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

    assign o_val      = r_val;
    assign o_next_val = n_val;

endmodule

// ===== design/sorted_min_queue_unit.sv =====
// Top level of the sorted minimum queue: decodes input beats, drives the cell chain
// and registers the result beat. Depends on smq_pkg and smq_cell.
//
// A bounded min priority queue of signed 32-bit values, kept in ascending order in
// a chain of DEPTH cells. Each input beat inserts a value, pops the smallest one,
// or clears the store (mode 3 does nothing), and yields exactly one result beat
// giving the smallest value, the count (taken modulo 32), an empty flag and a
// status. An insert into a full store is dropped with status FULL; a pop on an
// empty store is ignored with status EMPTY; the smallest value reads as 0 when
// the store is empty. Throughput is one beat per clock unless the consumer stalls:
// every cell compares its value against the new one and all cells move together,
// so the whole update is one pass through a 32-bit compare and a three-way select
// per cell. The result is registered and appears on the output in the cycle after
// the input beat is taken. The input is taken whenever the output register is empty
// or its beat is being taken in the same cycle, so the block stalls only when the
// consumer stalls. Values are not cleared at reset or on clear; only the count is,
// and a cell at or beyond the count never reaches a result beat.
module sorted_min_queue_unit
    import smq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_beat  i_in,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_beat o_out
);

    localparam int CW = $clog2(DEPTH + 1);

    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic          r_out_valid;
    logic          n_out_valid;
    t_out_beat     r_out;
    t_out_beat     n_out;

    logic                accept;
    logic                full;
    logic                empty;
    logic [STATUS_W-1:0] status;
    t_cell_ctl           ctl;

    logic                     lt       [DEPTH];
    logic                     occupied [DEPTH];
    logic signed [DATA_W-1:0] val      [DEPTH];
    logic signed [DATA_W-1:0] next_val [DEPTH];

    // A new beat is taken when the output register is free or draining now.
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;
    assign full       = (r_count == CW'(DEPTH));
    assign empty      = (r_count == '0);

    // Decode the operation into the cell control word and the new count.
    always_comb begin
        ctl.op    = CELL_HOLD;
        ctl.value = i_in.value;
        n_count   = r_count;
        status    = ST_OK;
        unique case (i_in.mode)
            MODE_INSERT: begin
                if (full) begin
                    status = ST_FULL;
                end else begin
                    ctl.op  = CELL_INSERT;
                    n_count = r_count + CW'(1);
                end
            end
            MODE_POP: begin
                if (empty) begin
                    status = ST_EMPTY;
                end else begin
                    ctl.op  = CELL_POP;
                    n_count = r_count - CW'(1);
                end
            end
            MODE_CLEAR: begin
                n_count = '0;
            end
            default: begin
                n_count = r_count;
            end
        endcase
        if (!accept) begin
            ctl.op  = CELL_HOLD;
            n_count = r_count;
        end
    end

    // The chain. The first cell sees a left neighbor that is always below the new
    // value, so it takes the new value whenever its own is not smaller.
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        assign occupied[g] = (r_count > CW'(g));

        if (g == 0) begin : g_first
            smq_cell u_cell (
                .i_clk      (i_clk),
                .i_ctl      (ctl),
                .i_occupied (occupied[g]),
                .i_prev_lt  (1'b1),
                .i_prev_val ('0),
                .i_next_val (val[g+1]),
                .o_lt       (lt[g]),
                .o_val      (val[g]),
                .o_next_val (next_val[g])
            );
        end else if (g == DEPTH - 1) begin : g_last
            smq_cell u_cell (
                .i_clk      (i_clk),
                .i_ctl      (ctl),
                .i_occupied (occupied[g]),
                .i_prev_lt  (lt[g-1]),
                .i_prev_val (val[g-1]),
                .i_next_val (val[g]),
                .o_lt       (lt[g]),
                .o_val      (val[g]),
                .o_next_val (next_val[g])
            );
        end else begin : g_mid
            smq_cell u_cell (
                .i_clk      (i_clk),
                .i_ctl      (ctl),
                .i_occupied (occupied[g]),
                .i_prev_lt  (lt[g-1]),
                .i_prev_val (val[g-1]),
                .i_next_val (val[g+1]),
                .o_lt       (lt[g]),
                .o_val      (val[g]),
                .o_next_val (next_val[g])
            );
        end
    end

    // The result reflects the store after this beat's update.
    always_comb begin
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        if (accept) begin
            n_out_valid     = 1'b1;
            n_out.min_value = (n_count == '0) ? '0 : next_val[0];
            n_out.count     = OUT_COUNT_W'(n_count);
            n_out.is_empty  = (n_count == '0);
            n_out.status    = status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // The last cell's compare result and every lookahead but the first have no reader in the block.
    logic unused_tail;
    assign unused_tail = lt[DEPTH-1] ^ (|next_val[DEPTH-1]);

endmodule

// ===== design/smq_checker.sv =====
// Port-level checks for the sorted minimum queue, bound to the top level.
// Depends on smq_pkg and sorted_min_queue_unit.
module smq_checker
    import smq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_ready,
    input t_in_beat  i_in,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_beat o_out
);

    // A result that is not taken stays on the port unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out))
        else $error("result beat changed while stalled");

    // An empty store reports a zero count and a zero minimum.
    a_empty_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.is_empty |-> o_out.count == '0 && o_out.min_value == '0)
        else $error("empty result with nonzero fields");

    // A dropped insert only happens when the store is at its depth.
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.status == ST_FULL |->
            o_out.count == OUT_COUNT_W'(DEPTH) && !o_out.is_empty)
        else $error("full status with wrong count");

    // An ignored pop only happens on an empty store.
    a_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.status == ST_EMPTY |-> o_out.is_empty)
        else $error("empty status on a nonempty store");

    // A clear yields an empty result on the next cycle.
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_in.mode == MODE_CLEAR |=>
            o_out_valid && o_out.is_empty && o_out.status == ST_OK)
        else $error("clear did not empty the store");

endmodule

bind sorted_min_queue_unit smq_checker #(.DEPTH(DEPTH)) u_smq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in        (i_in),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out       (o_out)
);

// ===== dv/tb_sorted_min_queue_unit.sv =====
`timescale 1ns / 1ps
// Testbench for sorted_min_queue_unit: a directed table and random beats with random stalls,
// each result checked against an in-bench model of the sorted queue. Depends on smq_pkg.
module tb_sorted_min_queue_unit;
    import smq_pkg::*;

    localparam int CLK_HALF       = 6;
    localparam int RESET_CYCLES   = 12;
    localparam int QUEUE_DEPTH    = DEPTH_DEFAULT;
    localparam int RANDOM_BEATS   = 500;
    localparam int MAX_GAP        = 18;
    localparam int LONG_HOLD      = 120;
    localparam int WATCHDOG_LIMIT = 2000;

    // Mode 3 has no code in the package; the block treats it as a no-op.
    localparam logic [MODE_W-1:0] MODE_NOP = 2'd3;

    localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;

    typedef struct {
        t_in_beat  beat;
        bit        typed;
        t_out_beat want;
    } t_stim_row;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    t_in_beat  in_beat = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_beat out_beat;

    // Typed expectation travelling alongside the beat that is on offer.
    bit        row_typed = 1'b0;
    t_out_beat row_want = '0;

    logic signed [DATA_W-1:0] model_sorted[$];
    t_out_beat                pending_results[$];
    t_stim_row                stim_rows[$];

    int  fail_count = 0;
    int  idle_cycles = 0;
    int  n_insert = 0, n_pop = 0, n_clear = 0, n_nop = 0;
    int  n_full = 0, n_empty = 0, peak_count = 0;
    bit  long_hold_req = 1'b0;
    bit  tx_quiet = 1'b0;

    sorted_min_queue_unit #(
        .DEPTH(QUEUE_DEPTH)
    ) DUT (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in       (in_beat),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out      (out_beat)
    );

    always begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // Applies one operation to the model queue and returns the result beat it yields.
    function automatic t_out_beat predict_queue_result(input t_in_beat b);
        t_out_beat r;
        int        pos;
        r.status = ST_OK;
        case (b.mode)
            MODE_INSERT: begin
                if (model_sorted.size() >= QUEUE_DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    // New value goes ahead of the first entry that is not smaller.
                    pos = 0;
                    while (pos < model_sorted.size() && model_sorted[pos] < $signed(b.value))
                        pos++;
                    model_sorted.insert(pos, $signed(b.value));
                end
            end
            MODE_POP: begin
                if (model_sorted.size() == 0)
                    r.status = ST_EMPTY;
                else
                    void'(model_sorted.pop_front());
            end
            MODE_CLEAR: begin
                model_sorted.delete();
            end
            default: ;
        endcase
        r.min_value = (model_sorted.size() != 0) ? model_sorted[0] : '0;
        r.count     = OUT_COUNT_W'(model_sorted.size());
        r.is_empty  = (model_sorted.size() == 0);
        return r;
    endfunction

    function automatic logic signed [DATA_W-1:0] draw_value();
        int pick;
        pick = $urandom_range(0, 7);
        case (pick)
            0: return VAL_MAX;
            1: return VAL_MIN;
            2, 3: return $signed($urandom_range(0, 16)) - 8;  // forces duplicates
            default: return $urandom;
        endcase
    endfunction

    task automatic add_row(input logic [MODE_W-1:0] mode, input logic signed [DATA_W-1:0] value,
                           input bit typed, input t_out_beat want);
        t_stim_row row;
        row.beat.mode  = mode;
        row.beat.value = value;
        row.typed      = typed;
        row.want       = want;
        stim_rows.push_back(row);
    endtask

    // Offers one beat after a random gap and returns at the edge where it is taken.
    // Nothing is assigned at that edge, so the next call may keep valid high.
    task automatic send_beat(input t_in_beat b, input bit typed, input t_out_beat want);
        int gap;
        gap = tx_quiet ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        in_beat   <= b;
        row_typed <= typed;
        row_want  <= want;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    // Checks result beats in order and predicts each beat as it is taken.
    always @(posedge clk) begin
        t_out_beat want;
        t_out_beat predicted;
        if (rst_n) begin
            if (out_valid && out_ready) begin
                if (pending_results.size() == 0) begin
                    $error("result beat with nothing expected: %p", out_beat);
                    fail_count++;
                end else begin
                    want = pending_results.pop_front();
                    if (out_beat.min_value !== want.min_value) begin
                        $error("min_value: expected %0d, actual %0d",
                               want.min_value, out_beat.min_value);
                        fail_count++;
                    end
                    if (out_beat.count !== want.count) begin
                        $error("count: expected %0d, actual %0d", want.count, out_beat.count);
                        fail_count++;
                    end
                    if (out_beat.is_empty !== want.is_empty) begin
                        $error("is_empty: expected %0d, actual %0d",
                               want.is_empty, out_beat.is_empty);
                        fail_count++;
                    end
                    if (out_beat.status !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, out_beat.status);
                        fail_count++;
                    end
                end
            end
            if (in_valid && in_ready) begin
                predicted = predict_queue_result(in_beat);
                pending_results.push_back(row_typed ? row_want : predicted);
                case (in_beat.mode)
                    MODE_INSERT: n_insert++;
                    MODE_POP:    n_pop++;
                    MODE_CLEAR:  n_clear++;
                    default:     n_nop++;
                endcase
                if (predicted.status == ST_FULL)  n_full++;
                if (predicted.status == ST_EMPTY) n_empty++;
                if (predicted.count > peak_count) peak_count = predicted.count;
            end
        end
    end

    // Watchdog: ends the run if no beat moves on either side for too long.
    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $error("no beat accepted for %0d cycles, %0d results outstanding",
                   idle_cycles, pending_results.size());
            $display("tb_sorted_min_queue_unit NOT OK");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Result side: random stalls per beat, quiet stretches, and one long hold-off on request.
    initial begin
        int  gap;
        int  taken;
        bit  rx_quiet;
        taken    = 0;
        rx_quiet = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        forever begin
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            gap = rx_quiet ? 0 : $urandom_range(0, MAX_GAP);
            if (gap > 0) begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
            taken++;
            if (taken % 40 == 0) rx_quiet = ($urandom_range(0, 3) == 0);
        end
    end

    initial begin
        t_out_beat     none;
        t_in_beat      b;
        int            insert_pct;
        int            pick;
        int            i;
        none = '0;

        // Directed table: empty-store cases, extremes, duplicates, clear, then a fill to
        // the brim and one insert past it.
        add_row(MODE_POP, 0, 1'b1, '{min_value: 0, count: 0, is_empty: 1'b1, status: ST_EMPTY});
        add_row(MODE_NOP, -1, 1'b1, '{min_value: 0, count: 0, is_empty: 1'b1, status: ST_OK});
        add_row(MODE_INSERT, VAL_MAX, 1'b1,
                '{min_value: VAL_MAX, count: 1, is_empty: 1'b0, status: ST_OK});
        add_row(MODE_INSERT, VAL_MIN, 1'b1,
                '{min_value: VAL_MIN, count: 2, is_empty: 1'b0, status: ST_OK});
        add_row(MODE_INSERT, -1, 1'b0, none);
        add_row(MODE_INSERT, VAL_MIN, 1'b0, none);
        add_row(MODE_POP, VAL_MAX, 1'b0, none);
        add_row(MODE_CLEAR, 32'sh5A5A_A5A5, 1'b1,
                '{min_value: 0, count: 0, is_empty: 1'b1, status: ST_OK});
        for (i = 0; i < QUEUE_DEPTH; i++)
            add_row(MODE_INSERT, (i % 2) ? -(i * 3) : i * 5, 1'b0, none);
        add_row(MODE_INSERT, VAL_MAX, 1'b1,
                '{min_value: -45, count: OUT_COUNT_W'(QUEUE_DEPTH), is_empty: 1'b0,
                  status: ST_FULL});

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (stim_rows[k])
            send_beat(stim_rows[k].beat, stim_rows[k].typed, stim_rows[k].want);

        // Random part in stretches of 40 beats, each leaning toward filling, draining or
        // neither, so the store keeps crossing between empty and full.
        insert_pct = 50;
        for (i = 0; i < RANDOM_BEATS; i++) begin
            if (i % 40 == 0) begin
                pick       = $urandom_range(0, 2);
                insert_pct = (pick == 0) ? 85 : (pick == 1) ? 20 : 55;
                tx_quiet   = ($urandom_range(0, 3) == 0);
            end
            if (i == 150) begin
                // The result side stops while beats keep coming, so the input must stall.
                long_hold_req = 1'b1;
                tx_quiet      = 1'b1;
            end
            if (i == 350) begin
                in_valid <= 1'b0;
                do @(posedge clk); while (pending_results.size() != 0);
            end
            pick = $urandom_range(0, 99);
            if (pick < 3)
                b.mode = MODE_CLEAR;
            else if (pick < 6)
                b.mode = MODE_NOP;
            else if (pick < 6 + insert_pct * 94 / 100)
                b.mode = MODE_INSERT;
            else
                b.mode = MODE_POP;
            b.value = draw_value();
            send_beat(b, 1'b0, none);
        end
        in_valid <= 1'b0;

        do @(posedge clk); while (pending_results.size() != 0);
        repeat (4) @(posedge clk);

        $display("Ran %0d beats: %0d inserts, %0d pops, %0d clears, %0d no-ops.",
                 stim_rows.size() + RANDOM_BEATS, n_insert, n_pop, n_clear, n_nop);
        $display("Inserts dropped on a full store: %0d, pops on an empty store: %0d,",
                 n_full, n_empty);
        $display("peak count %0d.", peak_count);
        if (fail_count == 0)
            $display("tb_sorted_min_queue_unit OK");
        else
            $display("tb_sorted_min_queue_unit NOT OK");
        $finish;
    end

endmodule
